@@ rtl/core/mvna_pkg.sv @@
// Package for the mesh vertex normal accumulator.
// Holds request/response types, operation and status codes, state enums and Q-format helpers.
// No dependencies.
`timescale 1ns / 1ps

package mvna_pkg;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FACE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_AREA = 2'd1;
    localparam logic [1:0] STAT_ZERO_LEN  = 2'd2;
    localparam logic [1:0] STAT_UNREF     = 2'd3;

    // Datapath widths
    localparam int VEC_W   = 63;   // signed vector component into the unit
    localparam int MAG_W   = 62;   // magnitude of a component
    localparam int Q_W     = 31;   // Q1.30 magnitude out of the unit
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
    } req_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } vtx_t;

    typedef struct packed {
        logic signed [31:0]   sum_x;
        logic signed [31:0]   sum_y;
        logic signed [31:0]   sum_z;
        logic [COUNT_W-1:0]   count;
    } acc_t;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic [Q_W-1:0]          quo_t;

    // Unit handshake groups
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic nonzero;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_UNIT1,
        ST_UNIT2,
        ST_CROSS,
        ST_UNIT3,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_DATA,
        ST_UNIT4,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MAX,
        U_NORM,
        U_SQ,
        U_SQRT,
        U_DINIT,
        U_DIV,
        U_DONE
    } unit_state_t;

    // Q1.30 magnitude and sign to Q1.15: round half away from zero, saturate positive side
    function automatic logic signed [15:0] to_q15(input quo_t q, input logic neg);
        logic [Q_W-1:0] r;
        logic [15:0]    r16;
        r   = (q + Q_W'(32'h4000)) >> 15;
        r16 = r[15:0];
        if (neg) begin
            return -r16;
        end
        if (r16 > 16'd32767) begin
            return 16'sd32767;
        end
        return r16;
    endfunction

    // Q1.30 magnitude and sign to signed 32-bit
    function automatic logic signed [31:0] to_q30(input quo_t q, input logic neg);
        logic [31:0] v;
        v = {1'b0, q};
        return neg ? -v : v;
    endfunction

endpackage

@@ rtl/core/mvna_unit.sv @@
// Vector normalizer: turns a signed 3-vector into a Q1.30 unit vector (magnitudes and signs).
// Shift normalization, serial sum of squares, bit-serial square root and division.
// Depends on mvna_pkg.
`timescale 1ns / 1ps

module mvna_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mvna_pkg::unit_ctl_t     ctl,
    input  mvna_pkg::vec_t          vec [3],
    output mvna_pkg::unit_stat_t    stat,
    output mvna_pkg::quo_t          quo [3],
    output logic                    neg [3]
);

    localparam int MW = mvna_pkg::MAG_W;
    localparam logic [MW-1:0] M_HI4 = MW'(64'd1 << 34);
    localparam logic [MW-1:0] M_HI1 = MW'(64'd1 << 30);
    localparam logic [MW-1:0] M_LO4 = MW'(64'd1 << 25);
    localparam logic [MW-1:0] M_LO1 = MW'(64'd1 << 29);

    mvna_pkg::unit_state_t state_reg, state_next;

    logic [MW-1:0]       mag_reg [3];
    logic                neg_reg [3];
    logic [MW-1:0]       m_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          comp_reg;
    logic [59:0]         sq_reg;
    logic [MW-1:0]       sum_reg;
    logic [31:0]         rem_reg;
    logic [30:0]         root_reg;
    logic [30:0]         drem_reg;
    logic [30:0]         nlow_reg;
    logic [30:0]         quo_reg;
    mvna_pkg::quo_t      q_reg [3];
    logic                nz_reg;

    logic [MW-1:0]       mag_in [3];
    logic [MW-1:0]       max_ab;
    logic [MW-1:0]       max3;
    logic [59:0]         sq_full;
    logic [33:0]         sq_r2;
    logic [33:0]         sq_t;
    logic                sq_take;
    logic [31:0]         dv_r2;
    logic                dv_take;
    logic [30:0]         quo_step;
    logic [60:0]         num;

    // Input magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vec[i][mvna_pkg::VEC_W-1] ? MW'(-vec[i]) : MW'(vec[i]);
        end
    end

    // Step logic
    always_comb
    begin
        max_ab   = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max3     = (mag_reg[2] > max_ab) ? mag_reg[2] : max_ab;
        sq_full  = mag_reg[cnt_reg[1:0]][29:0] * mag_reg[cnt_reg[1:0]][29:0];
        sq_r2    = {rem_reg, sum_reg[MW-1:MW-2]};
        sq_t     = {1'b0, root_reg, 2'b01};
        sq_take  = (sq_r2 >= sq_t);
        dv_r2    = {drem_reg, nlow_reg[30]};
        dv_take  = (dv_r2 >= {1'b0, root_reg});
        quo_step = {quo_reg[29:0], dv_take};
        num      = {1'b0, mag_reg[comp_reg][29:0], 30'd0} + 61'(root_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvna_pkg::U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvna_pkg::U_IDLE, mvna_pkg::U_DONE:
            begin
                state_next = ctl.start ? mvna_pkg::U_MAX : mvna_pkg::U_IDLE;
            end
            mvna_pkg::U_MAX:
            begin
                state_next = mvna_pkg::U_NORM;
            end
            mvna_pkg::U_NORM:
            begin
                if (m_reg == '0)
                begin
                    state_next = mvna_pkg::U_DONE;
                end
                else if (m_reg < M_HI1 && m_reg >= M_LO1)
                begin
                    state_next = mvna_pkg::U_SQ;
                end
            end
            mvna_pkg::U_SQ:
            begin
                if (cnt_reg == 5'd3)
                begin
                    state_next = mvna_pkg::U_SQRT;
                end
            end
            mvna_pkg::U_SQRT:
            begin
                if (cnt_reg == 5'd30)
                begin
                    state_next = mvna_pkg::U_DINIT;
                end
            end
            mvna_pkg::U_DINIT:
            begin
                state_next = mvna_pkg::U_DIV;
            end
            mvna_pkg::U_DIV:
            begin
                if (cnt_reg == 5'd30)
                begin
                    state_next = (comp_reg == 2'd2) ? mvna_pkg::U_DONE : mvna_pkg::U_DINIT;
                end
            end
        endcase
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mvna_pkg::U_IDLE, mvna_pkg::U_DONE:
            begin
                if (ctl.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_in[i];
                        neg_reg[i] <= vec[i][mvna_pkg::VEC_W-1];
                    end
                end
            end
            mvna_pkg::U_MAX:
            begin
                m_reg <= max3;
            end
            mvna_pkg::U_NORM:
            begin
                if (m_reg == '0)
                begin
                    nz_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        q_reg[i] <= '0;
                    end
                end
                else if (m_reg >= M_HI4)
                begin
                    m_reg <= m_reg >> 4;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 4;
                    end
                end
                else if (m_reg >= M_HI1)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (m_reg < M_LO4)
                begin
                    m_reg <= m_reg << 4;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 4;
                    end
                end
                else if (m_reg < M_LO1)
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                else
                begin
                    nz_reg  <= 1'b1;
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            mvna_pkg::U_SQ:
            begin
                // square register feeds the adder in the next cycle
                if (cnt_reg < 5'd3)
                begin
                    sq_reg <= sq_full;
                end
                if (cnt_reg != 5'd0)
                begin
                    sum_reg <= sum_reg + MW'(sq_reg);
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            mvna_pkg::U_SQRT:
            begin
                // one root bit per cycle
                rem_reg  <= sq_take ? 32'(sq_r2 - sq_t) : sq_r2[31:0];
                root_reg <= {root_reg[29:0], sq_take};
                sum_reg  <= sum_reg << 2;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    comp_reg <= '0;
                end
            end
            mvna_pkg::U_DINIT:
            begin
                // rounded numerator; high part is already below the divisor
                drem_reg <= {1'b0, num[60:31]};
                nlow_reg <= num[30:0];
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            mvna_pkg::U_DIV:
            begin
                drem_reg <= dv_take ? 31'(dv_r2 - {1'b0, root_reg}) : dv_r2[30:0];
                nlow_reg <= nlow_reg << 1;
                quo_reg  <= quo_step;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    q_reg[comp_reg] <= quo_step;
                    comp_reg        <= comp_reg + 2'd1;
                end
            end
        endcase
    end

    assign stat.idle    = (state_reg == mvna_pkg::U_IDLE) || (state_reg == mvna_pkg::U_DONE);
    assign stat.done    = (state_reg == mvna_pkg::U_DONE);
    assign stat.nonzero = nz_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = q_reg[i];
            neg[i] = neg_reg[i];
        end
    end

endmodule

@@ rtl/core/mesh_vertex_normal_accumulator.sv @@
// Response path: load and clear go from decode straight to the output state; a read of a
// counted vertex takes one normalizer pass; add face takes three passes of the normalizer
// (each a shift normalization, a sum of squares, a bit-serial square root and three 31-step
// divisions) plus 3 accumulator read-modify-writes.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: state clears at once, then a sweep over all MAX_VERTICES entries zeroes the accumulator memory
// while no request is taken. Vertex memory is not cleared.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mvna_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mvna_pkg::rsp_t  rsp
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CMP_W  = ((ADDR_W > 10) ? ADDR_W : 10) + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);

    function automatic logic idx_ok(input logic [9:0] idx);
        return CMP_W'(idx) < CMP_W'(MAX_VERTICES);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [9:0] idx);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(idx);
        return ext[ADDR_W-1:0];
    endfunction

    mvna_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               rsp_valid_reg;
    mvna_pkg::rsp_t     rsp_reg;

    mvna_pkg::req_t     req_reg;
    mvna_pkg::vtx_t     pa_reg;
    mvna_pkg::vec_t     e1_reg [3];
    mvna_pkg::vec_t     e2_reg [3];
    logic signed [31:0] t1_reg [3];
    logic signed [31:0] t2_reg [3];
    mvna_pkg::vec_t     prod_reg;
    mvna_pkg::vec_t     cp_reg [3];
    logic signed [15:0] res_reg [3];
    logic [1:0]         status_reg;

    // Memories
    mvna_pkg::vtx_t     vtx_mem [MAX_VERTICES];
    mvna_pkg::acc_t     acc_mem [MAX_VERTICES];
    mvna_pkg::vtx_t     vtx_rdata_reg;
    mvna_pkg::acc_t     acc_rdata_reg;

    logic               vtx_we, vtx_re, acc_we, acc_re;
    logic [ADDR_W-1:0]  vtx_waddr, vtx_raddr, acc_waddr, acc_raddr;
    mvna_pkg::vtx_t     vtx_wdata;
    mvna_pkg::acc_t     acc_wdata;

    // Normalizer
    mvna_pkg::unit_ctl_t  unit_ctl;
    mvna_pkg::unit_stat_t unit_stat;
    mvna_pkg::vec_t       unit_vec [3];
    mvna_pkg::quo_t       unit_q [3];
    logic                 unit_neg [3];

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_full;
    logic               face_ok;
    logic [ADDR_W-1:0]  corner_addr;
    logic               out_free;

    mvna_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (unit_ctl),
        .vec   (unit_vec),
        .stat  (unit_stat),
        .quo   (unit_q),
        .neg   (unit_neg)
    );

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[vtx_waddr] <= vtx_wdata;
        end
        if (vtx_re)
        begin
            vtx_rdata_reg <= vtx_mem[vtx_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re)
        begin
            acc_rdata_reg <= acc_mem[acc_raddr];
        end
    end

    // Cross product operand select
    always_comb
    begin
        unique case (cnt_reg)
            3'd0:    begin mul_a = t1_reg[1]; mul_b = t2_reg[2]; end
            3'd1:    begin mul_a = t2_reg[1]; mul_b = t1_reg[2]; end
            3'd2:    begin mul_a = t2_reg[0]; mul_b = t1_reg[2]; end
            3'd3:    begin mul_a = t1_reg[0]; mul_b = t2_reg[2]; end
            3'd4:    begin mul_a = t1_reg[0]; mul_b = t2_reg[1]; end
            3'd5:    begin mul_a = t2_reg[0]; mul_b = t1_reg[1]; end
            default: begin mul_a = t1_reg[0]; mul_b = t2_reg[0]; end
        endcase
        prod_full = mul_a * mul_b;
    end

    always_comb
    begin
        face_ok = idx_ok(req_reg.corner_a) && idx_ok(req_reg.corner_b)
                  && idx_ok(req_reg.corner_c);
        unique case (cnt_reg[1:0])
            2'd0:    corner_addr = to_addr(req_reg.corner_a);
            2'd1:    corner_addr = to_addr(req_reg.corner_b);
            default: corner_addr = to_addr(req_reg.corner_c);
        endcase
        out_free = !rsp_valid_reg || rsp_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvna_pkg::ST_INIT;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    // Sequencer: next state, memory controls, normalizer start
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        req_ready     = 1'b0;
        vtx_we        = 1'b0;
        vtx_waddr     = to_addr(req_reg.vertex_index);
        vtx_wdata     = '{pos_x: req_reg.pos_x, pos_y: req_reg.pos_y, pos_z: req_reg.pos_z};
        vtx_re        = 1'b0;
        vtx_raddr     = to_addr(req_reg.corner_a);
        acc_we        = 1'b0;
        acc_waddr     = to_addr(req_reg.vertex_index);
        acc_wdata     = '0;
        acc_re        = 1'b0;
        acc_raddr     = to_addr(req_reg.vertex_index);
        unit_ctl      = '0;
        for (int i = 0; i < 3; i++)
        begin
            unit_vec[i] = e1_reg[i];
        end

        unique case (state_reg)
            mvna_pkg::ST_INIT:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            mvna_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = mvna_pkg::ST_DECODE;
                end
            end
            mvna_pkg::ST_DECODE:
            begin
                state_next = mvna_pkg::ST_OUT;
                unique case (req_reg.operation)
                    mvna_pkg::OP_LOAD:
                    begin
                        vtx_we = idx_ok(req_reg.vertex_index);
                    end
                    mvna_pkg::OP_CLEAR:
                    begin
                        acc_we = idx_ok(req_reg.vertex_index);
                    end
                    mvna_pkg::OP_FACE:
                    begin
                        if (face_ok)
                        begin
                            vtx_re     = 1'b1;
                            state_next = mvna_pkg::ST_FETCH_A;
                        end
                    end
                    mvna_pkg::OP_READ:
                    begin
                        if (idx_ok(req_reg.vertex_index))
                        begin
                            acc_re     = 1'b1;
                            state_next = mvna_pkg::ST_RD_DATA;
                        end
                    end
                endcase
            end
            mvna_pkg::ST_FETCH_A:
            begin
                vtx_re     = 1'b1;
                vtx_raddr  = to_addr(req_reg.corner_b);
                state_next = mvna_pkg::ST_FETCH_B;
            end
            mvna_pkg::ST_FETCH_B:
            begin
                vtx_re     = 1'b1;
                vtx_raddr  = to_addr(req_reg.corner_c);
                state_next = mvna_pkg::ST_FETCH_C;
            end
            mvna_pkg::ST_FETCH_C:
            begin
                unit_ctl.start = 1'b1;
                state_next     = mvna_pkg::ST_UNIT1;
            end
            mvna_pkg::ST_UNIT1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    unit_vec[i] = e2_reg[i];
                end
                if (unit_stat.done)
                begin
                    unit_ctl.start = 1'b1;
                    state_next     = mvna_pkg::ST_UNIT2;
                end
            end
            mvna_pkg::ST_UNIT2:
            begin
                if (unit_stat.done)
                begin
                    cnt_next   = '0;
                    state_next = mvna_pkg::ST_CROSS;
                end
            end
            mvna_pkg::ST_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    unit_vec[i] = cp_reg[i];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    unit_ctl.start = 1'b1;
                    state_next     = mvna_pkg::ST_UNIT3;
                end
            end
            mvna_pkg::ST_UNIT3:
            begin
                if (unit_stat.done)
                begin
                    cnt_next   = '0;
                    state_next = mvna_pkg::ST_ACC_RD;
                end
            end
            mvna_pkg::ST_ACC_RD:
            begin
                acc_re     = 1'b1;
                acc_raddr  = corner_addr;
                state_next = mvna_pkg::ST_ACC_WR;
            end
            mvna_pkg::ST_ACC_WR:
            begin
                // saturated counts take no further contribution
                acc_we    = (acc_rdata_reg.count != mvna_pkg::COUNT_MAX);
                acc_waddr = corner_addr;
                acc_wdata = '{sum_x: acc_rdata_reg.sum_x + 32'(res_reg[0]),
                              sum_y: acc_rdata_reg.sum_y + 32'(res_reg[1]),
                              sum_z: acc_rdata_reg.sum_z + 32'(res_reg[2]),
                              count: acc_rdata_reg.count + 16'd1};
                cnt_next  = cnt_reg + 3'd1;
                state_next = (cnt_reg == 3'd2) ? mvna_pkg::ST_OUT : mvna_pkg::ST_ACC_RD;
            end
            mvna_pkg::ST_RD_DATA:
            begin
                unit_vec[0] = mvna_pkg::VEC_W'(acc_rdata_reg.sum_x);
                unit_vec[1] = mvna_pkg::VEC_W'(acc_rdata_reg.sum_y);
                unit_vec[2] = mvna_pkg::VEC_W'(acc_rdata_reg.sum_z);
                if (acc_rdata_reg.count == '0)
                begin
                    state_next = mvna_pkg::ST_OUT;
                end
                else
                begin
                    unit_ctl.start = 1'b1;
                    state_next     = mvna_pkg::ST_UNIT4;
                end
            end
            mvna_pkg::ST_UNIT4:
            begin
                if (unit_stat.done)
                begin
                    state_next = mvna_pkg::ST_OUT;
                end
            end
            mvna_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mvna_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_reg <= req;
                end
            end
            mvna_pkg::ST_DECODE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= '0;
                end
                if ((req_reg.operation == mvna_pkg::OP_FACE && !face_ok) ||
                    (req_reg.operation == mvna_pkg::OP_READ &&
                     !idx_ok(req_reg.vertex_index)))
                begin
                    status_reg <= mvna_pkg::STAT_UNREF;
                end
                else
                begin
                    status_reg <= mvna_pkg::STAT_OK;
                end
            end
            mvna_pkg::ST_FETCH_A:
            begin
                pa_reg <= vtx_rdata_reg;
            end
            mvna_pkg::ST_FETCH_B:
            begin
                e1_reg[0] <= mvna_pkg::VEC_W'(pa_reg.pos_x) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_x);
                e1_reg[1] <= mvna_pkg::VEC_W'(pa_reg.pos_y) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_y);
                e1_reg[2] <= mvna_pkg::VEC_W'(pa_reg.pos_z) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_z);
            end
            mvna_pkg::ST_FETCH_C:
            begin
                e2_reg[0] <= mvna_pkg::VEC_W'(pa_reg.pos_x) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_x);
                e2_reg[1] <= mvna_pkg::VEC_W'(pa_reg.pos_y) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_y);
                e2_reg[2] <= mvna_pkg::VEC_W'(pa_reg.pos_z) - mvna_pkg::VEC_W'(vtx_rdata_reg.pos_z);
            end
            mvna_pkg::ST_UNIT1:
            begin
                if (unit_stat.done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        t1_reg[i] <= mvna_pkg::to_q30(unit_q[i], unit_neg[i]);
                    end
                end
            end
            mvna_pkg::ST_UNIT2:
            begin
                if (unit_stat.done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        t2_reg[i] <= mvna_pkg::to_q30(unit_q[i], unit_neg[i]);
                    end
                end
            end
            mvna_pkg::ST_CROSS:
            begin
                // product of step n is folded in at step n+1
                if (cnt_reg < 3'd6)
                begin
                    prod_reg <= prod_full[mvna_pkg::VEC_W-1:0];
                end
                unique case (cnt_reg)
                    3'd1:    cp_reg[0] <= prod_reg;
                    3'd2:    cp_reg[0] <= cp_reg[0] - prod_reg;
                    3'd3:    cp_reg[1] <= prod_reg;
                    3'd4:    cp_reg[1] <= cp_reg[1] - prod_reg;
                    3'd5:    cp_reg[2] <= prod_reg;
                    3'd6:    cp_reg[2] <= cp_reg[2] - prod_reg;
                    default: ;
                endcase
            end
            mvna_pkg::ST_UNIT3:
            begin
                if (unit_stat.done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_reg[i] <= mvna_pkg::to_q15(unit_q[i], unit_neg[i]);
                    end
                    status_reg <= unit_stat.nonzero ? mvna_pkg::STAT_OK
                                                    : mvna_pkg::STAT_ZERO_AREA;
                end
            end
            mvna_pkg::ST_RD_DATA:
            begin
                if (acc_rdata_reg.count == '0)
                begin
                    status_reg <= mvna_pkg::STAT_UNREF;
                end
            end
            mvna_pkg::ST_UNIT4:
            begin
                if (unit_stat.done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_reg[i] <= mvna_pkg::to_q15(unit_q[i], unit_neg[i]);
                    end
                    status_reg <= unit_stat.nonzero ? mvna_pkg::STAT_OK
                                                    : mvna_pkg::STAT_ZERO_LEN;
                end
            end
            mvna_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    rsp_reg <= '{normal_x: res_reg[0], normal_y: res_reg[1],
                                 normal_z: res_reg[2], status: status_reg};
                end
            end
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == mvna_pkg::ST_OUT && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        unit_ctl.start |-> unit_stat.idle)
        else $error("normalizer started while busy");

    a_acc_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_we && acc_re) |-> (acc_waddr != acc_raddr))
        else $error("accumulator read and write hit the same entry");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while one is in progress");

endmodule

@@ test/mesh_vertex_normal_accumulator_test.sv @@
// Self-checking testbench for mesh_vertex_normal_accumulator: vertex loads, face adds,
// normal reads and clears, checked against a fixed-point vertex normal predictor.
// Depends on mvna_pkg and the mesh_vertex_normal_accumulator RTL.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator_test;

    localparam int NVERT     = 1024;
    localparam int POOL      = 16;
    localparam int SHOW_MAX  = 10;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef longint vec3_t [3];
    typedef int     tri_t [3];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    mvna_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    mvna_pkg::rsp_t rsp;

    mesh_vertex_normal_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    int          pos_mem [NVERT][3];
    int          sum_mem [NVERT][3];
    int unsigned cnt_mem [NVERT];
    bit          loaded [NVERT];
    int          loaded_list [$];

    mvna_pkg::rsp_t pending_normals [$];
    int   mismatches = 0;
    int   burst_left = 0;

    // Integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length in Q1.30; zero vector gives zeros and 0
    function automatic bit to_unit(input vec3_t v, output tri_t u);
        longint unsigned mag [3];
        longint unsigned m, acc, len, q;
        bit neg [3];
        m = 0;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        while (m >= ONE_Q30)
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (m < (ONE_Q30 >> 1))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            acc += mag[i] * mag[i];
        len = isqrt(acc);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = neg[i] ? -int'(q) : int'(q);
        end
        return 1'b1;
    endfunction

    // Q1.30 to Q1.15, round half away from zero, saturate positive side
    function automatic int q30_q15(input int v);
        int unsigned mag, r;
        mag = (v < 0) ? -v : v;
        r = (mag + 32'h4000) >> 15;
        if (v < 0)
            return -int'(r);
        return (r > 32767) ? 32767 : int'(r);
    endfunction

    function automatic mvna_pkg::rsp_t pack_rsp(input tri_t n, input logic [1:0] st);
        mvna_pkg::rsp_t r;
        r.normal_x = n[0][15:0];
        r.normal_y = n[1][15:0];
        r.normal_z = n[2][15:0];
        r.status   = st;
        return r;
    endfunction

    // Apply one request to the predictor and return the expected response
    function automatic mvna_pkg::rsp_t predict_normal(input mvna_pkg::req_t r);
        tri_t   zero3, t1, t2, fn, res;
        vec3_t  e1, e2, cp, s;
        bit     nz;
        int     vi;
        int     c [3];
        zero3 = '{0, 0, 0};
        vi = r.vertex_index;
        case (r.operation)
            mvna_pkg::OP_LOAD:
            begin
                pos_mem[vi][0] = r.pos_x;
                pos_mem[vi][1] = r.pos_y;
                pos_mem[vi][2] = r.pos_z;
                return pack_rsp(zero3, mvna_pkg::STAT_OK);
            end
            mvna_pkg::OP_FACE:
            begin
                c = '{r.corner_a, r.corner_b, r.corner_c};
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = longint'(pos_mem[c[0]][i]) - longint'(pos_mem[c[1]][i]);
                    e2[i] = longint'(pos_mem[c[0]][i]) - longint'(pos_mem[c[2]][i]);
                end
                void'(to_unit(e1, t1));
                void'(to_unit(e2, t2));
                cp[0] = longint'(t1[1]) * t2[2] - longint'(t2[1]) * t1[2];
                cp[1] = longint'(t2[0]) * t1[2] - longint'(t1[0]) * t2[2];
                cp[2] = longint'(t1[0]) * t2[1] - longint'(t2[0]) * t1[1];
                nz = to_unit(cp, fn);
                for (int i = 0; i < 3; i++)
                    res[i] = q30_q15(fn[i]);
                // each corner listing counts, saturated counts stop accumulating
                for (int k = 0; k < 3; k++)
                begin
                    if (cnt_mem[c[k]] < 65535)
                    begin
                        for (int i = 0; i < 3; i++)
                            sum_mem[c[k]][i] += res[i];
                        cnt_mem[c[k]]++;
                    end
                end
                return pack_rsp(res, nz ? mvna_pkg::STAT_OK : mvna_pkg::STAT_ZERO_AREA);
            end
            mvna_pkg::OP_READ:
            begin
                if (cnt_mem[vi] == 0)
                    return pack_rsp(zero3, mvna_pkg::STAT_UNREF);
                for (int i = 0; i < 3; i++)
                    s[i] = sum_mem[vi][i];
                if (!to_unit(s, t1))
                    return pack_rsp(zero3, mvna_pkg::STAT_ZERO_LEN);
                for (int i = 0; i < 3; i++)
                    res[i] = q30_q15(t1[i]);
                return pack_rsp(res, mvna_pkg::STAT_OK);
            end
            default:
            begin
                sum_mem[vi] = '{0, 0, 0};
                cnt_mem[vi] = 0;
                return pack_rsp(zero3, mvna_pkg::STAT_OK);
            end
        endcase
    endfunction

    // Send one request; bursts of random length, most of them separated by random gaps
    task automatic send_request(input mvna_pkg::req_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        if (r.operation == mvna_pkg::OP_LOAD && !loaded[r.vertex_index])
        begin
            loaded[r.vertex_index] = 1'b1;
            loaded_list.push_back(r.vertex_index);
        end
        pending_normals.push_back(predict_normal(r));
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Random request with noise in unused fields
    function automatic mvna_pkg::req_t noise_req(input logic [1:0] op);
        mvna_pkg::req_t r;
        r.operation    = op;
        r.vertex_index = $urandom_range(0, NVERT - 1);
        r.pos_x        = $urandom;
        r.pos_y        = $urandom;
        r.pos_z        = $urandom;
        r.corner_a     = $urandom_range(0, NVERT - 1);
        r.corner_b     = $urandom_range(0, NVERT - 1);
        r.corner_c     = $urandom_range(0, NVERT - 1);
        return r;
    endfunction

    task automatic do_load(input int vi, input int x, input int y, input int z);
        mvna_pkg::req_t r;
        r = noise_req(mvna_pkg::OP_LOAD);
        r.vertex_index = vi;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        send_request(r);
    endtask

    task automatic do_face(input int a, input int b, input int c);
        mvna_pkg::req_t r;
        r = noise_req(mvna_pkg::OP_FACE);
        r.corner_a = a;
        r.corner_b = b;
        r.corner_c = c;
        send_request(r);
    endtask

    task automatic do_single(input logic [1:0] op, input int vi);
        mvna_pkg::req_t r;
        r = noise_req(op);
        r.vertex_index = vi;
        send_request(r);
    endtask

    // Basic triangle, extreme coordinates, collinear corners
    task automatic test_face_shapes;
        do_load(0, 0, 0, 0);
        do_load(1, 32'h0001_0000, 0, 0);
        do_load(2, 0, 32'h0001_0000, 0);
        do_face(0, 1, 2);
        do_face(0, 2, 1);
        do_load(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        do_load(512, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        do_face(1023, 512, 0);
        do_face(512, 1023, 1);
        do_face(0, 0, 0);
        do_face(1, 1, 2);
    endtask

    // Reads of counted, never-counted and cancelled vertices, plus clears
    task automatic test_read_clear;
        do_single(mvna_pkg::OP_READ, 0);
        do_single(mvna_pkg::OP_READ, 1023);
        do_single(mvna_pkg::OP_READ, 5);
        do_single(mvna_pkg::OP_CLEAR, 0);
        do_single(mvna_pkg::OP_READ, 0);
        do_face(0, 0, 0);
        do_single(mvna_pkg::OP_READ, 0);
        do_single(mvna_pkg::OP_CLEAR, 1023);
        do_single(mvna_pkg::OP_READ, 1023);
        do_single(mvna_pkg::OP_CLEAR, 777);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0001_0000) - 32'h8000;
            default: return int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic int pick_vertex();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, POOL - 1)
                                          : $urandom_range(0, NVERT - 1);
    endfunction

    // Random loads, faces, reads and clears, mostly over a small hot set of vertices; reads check the sums
    task automatic test_random_mesh(input int n_items);
        int sel, a, b, c;
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25 || loaded_list.size() < 3)
                do_load(pick_vertex(), rand_coord(), rand_coord(), rand_coord());
            else if (sel < 60)
            begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                if ($urandom_range(0, 9) == 0)
                    b = a;
                do_face(a, b, c);
            end
            else if (sel < 90)
                do_single(mvna_pkg::OP_READ, pick_vertex());
            else
                do_single(mvna_pkg::OP_CLEAR, pick_vertex());
        end
    endtask

    // Response checker and receiver stall pattern
    int          stall_mode = 0;
    int unsigned stall_cnt = 0;
    always @(posedge clk)
    begin
        mvna_pkg::rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (rsp.normal_x !== want.normal_x || rsp.normal_y !== want.normal_y ||
                    rsp.normal_z !== want.normal_z || rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d st=%0d, ",
                                  "got x=%0d y=%0d z=%0d st=%0d"},
                                 want.normal_x, want.normal_y, want.normal_z, want.status,
                                 rsp.normal_x, rsp.normal_y, rsp.normal_z, rsp.status);
                end
            end
        end
        stall_cnt++;
        if (stall_cnt[8:0] == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_face_shapes();
        test_read_clear();
        test_random_mesh(1530);
        req_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
